>>> design/mpd_pkg.sv
package mpd_pkg;

    localparam int POS_W    = 12;
    localparam int CURSOR_W = 13;
    localparam int BOUND_W  = 13;
    localparam int SCROLL_W = 32;
    localparam int BTN_W    = 3;

    localparam logic [1:0] OP_RX_BYTE     = 2'd0;
    localparam logic [1:0] OP_TAKE_SCROLL = 2'd1;
    localparam logic [1:0] OP_SET_POS     = 2'd2;

    localparam logic [1:0] CFG_FOUR_BYTE = 2'd0;
    localparam logic [1:0] CFG_WIDTH     = 2'd1;
    localparam logic [1:0] CFG_HEIGHT    = 2'd2;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_XDELTA = 2'd1;
    localparam logic [1:0] PH_YDELTA = 2'd2;
    localparam logic [1:0] PH_WHEEL  = 2'd3;

    localparam logic [BOUND_W-1:0] WIDTH_RESET  = 13'd80;
    localparam logic [BOUND_W-1:0] HEIGHT_RESET = 13'd25;

    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       rx_byte;
        logic             from_aux;
        logic [POS_W-1:0] new_x;
        logic [POS_W-1:0] new_y;
    } t_item;

    typedef struct packed {
        logic               four_byte_mode;
        logic [BOUND_W-1:0] width_bound;
        logic [BOUND_W-1:0] height_bound;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0]           pos_x;
        logic [POS_W-1:0]           pos_y;
        logic [BTN_W-1:0]           button_bits;
        logic signed [SCROLL_W-1:0] scroll_total;
        logic                       packet_done;
    } t_result;

endpackage

>>> design/mouse_packet_decoder.sv
// Mouse packet decoder.
// Input stream (s_axis_*): one request per cycle while s_axis_tready is high. tuser carries op and from_aux,
// tdata carries rx_byte, new_x and new_y. Op 0 feeds one received byte, op 1
// takes and clears the scroll total, op 2 loads the cursor position.
// Output stream (m_axis_*): exactly one result per request, in order. tdata
// carries pos_x, pos_y, button_bits and scroll_total; tuser is packet_done.
// Configuration channel (i_cfg_*): index 0 four_byte_mode, 1 width_bound,
// 2 height_bound; always ready, write only while the stream is idle.
// Pipeline: the input register loads at the accepting edge and the result
// register loads when the request advances, so m_axis is registered.
// Throughput: one request per cycle while m_axis is not stalled; the
// decode, delta add and clamp all fit between the two registers.
// Stall: when m_axis_tready is low with a result pending, the result register
// holds and the input register fills; s_axis_tready drops only when both are full.
// Reset (synchronous, active low): cursor, buttons, scroll total and packet
// phase clear; bounds return to 80 by 25, three-byte packets.
module mouse_packet_decoder #(
    parameter int COORD_LIMIT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // rx_byte[7:0], new_x[19:8], new_y[31:20]
    input  logic [2:0]  s_axis_tuser,   // op[1:0], from_aux[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // pos_x[11:0], pos_y[23:12], button_bits[26:24],
                                        // scroll_total[58:27], zero[63:59]
    output logic        m_axis_tuser,   // packet_done[0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    import mpd_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_cfg    r_cfg;
    t_result core_result;
    logic    advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.op       <= s_axis_tuser[1:0];
            r_in.from_aux <= s_axis_tuser[2];
            r_in.rx_byte  <= s_axis_tdata[7:0];
            r_in.new_x    <= s_axis_tdata[19:8];
            r_in.new_y    <= s_axis_tdata[31:20];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.four_byte_mode <= 1'b0;
            r_cfg.width_bound    <= WIDTH_RESET;
            r_cfg.height_bound   <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FOUR_BYTE: r_cfg.four_byte_mode <= i_cfg_data[0];
                CFG_WIDTH:     r_cfg.width_bound    <= i_cfg_data;
                CFG_HEIGHT:    r_cfg.height_bound   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mpd_core #(
        .COORD_LIMIT(COORD_LIMIT)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .i_cfg     (r_cfg),
        .o_result  (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.scroll_total, r_out.button_bits,
                            r_out.pos_y, r_out.pos_x};
    assign m_axis_tuser  = r_out.packet_done;

endmodule

>>> design/mpd_core.sv
module mpd_core #(
    parameter int COORD_LIMIT = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  mpd_pkg::t_item  i_item,
    input  mpd_pkg::t_cfg   i_cfg,
    output mpd_pkg::t_result o_result
);
    import mpd_pkg::*;

    logic [1:0]          r_phase, n_phase;
    logic [7:0]          r_header, n_header;
    logic [7:0]          r_x_byte, n_x_byte;
    logic [7:0]          r_y_byte, n_y_byte;
    logic [CURSOR_W-1:0] r_cursor_x, n_cursor_x;
    logic [CURSOR_W-1:0] r_cursor_y, n_cursor_y;
    logic [BTN_W-1:0]    r_buttons, n_buttons;
    logic [SCROLL_W-1:0] r_wheel, n_wheel;

    logic [BOUND_W-1:0]  w_lim;
    logic [BOUND_W-1:0]  h_lim;
    logic [7:0]          y_use;
    logic [8:0]          dx;
    logic [8:0]          dy;
    logic signed [14:0]  sum_x;
    logic signed [14:0]  sum_y;
    logic [CURSOR_W-1:0] clamp_x;
    logic [CURSOR_W-1:0] clamp_y;
    logic                motion;
    logic                wheel_add;
    logic [SCROLL_W-1:0] wheel_after;

    always_comb begin
        if (i_cfg.width_bound == '0) begin
            w_lim = BOUND_W'(1);
        end else if ({4'b0, i_cfg.width_bound} > 17'(COORD_LIMIT)) begin
            w_lim = BOUND_W'(COORD_LIMIT);
        end else begin
            w_lim = i_cfg.width_bound;
        end
        if (i_cfg.height_bound == '0) begin
            h_lim = BOUND_W'(1);
        end else if ({4'b0, i_cfg.height_bound} > 17'(COORD_LIMIT)) begin
            h_lim = BOUND_W'(COORD_LIMIT);
        end else begin
            h_lim = i_cfg.height_bound;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_header  = r_header;
        n_x_byte  = r_x_byte;
        n_y_byte  = r_y_byte;
        y_use     = r_y_byte;
        motion    = 1'b0;
        wheel_add = 1'b0;
        if (i_item.op == OP_RX_BYTE && i_item.from_aux) begin
            case (r_phase)
                PH_HEADER: begin
                    if (i_item.rx_byte[3]) begin
                        n_header = i_item.rx_byte;
                        n_phase  = PH_XDELTA;
                    end
                end
                PH_XDELTA: begin
                    n_x_byte = i_item.rx_byte;
                    n_phase  = PH_YDELTA;
                end
                PH_YDELTA: begin
                    n_y_byte = i_item.rx_byte;
                    y_use    = i_item.rx_byte;
                    if (i_cfg.four_byte_mode) begin
                        n_phase = PH_WHEEL;
                    end else begin
                        n_phase = PH_HEADER;
                        motion  = 1'b1;
                    end
                end
                default: begin
                    n_phase   = PH_HEADER;
                    motion    = 1'b1;
                    wheel_add = 1'b1;
                end
            endcase
        end
    end

    assign dx    = {r_header[4], r_x_byte};
    assign dy    = {r_header[5], y_use};
    assign sum_x = $signed({2'b0, r_cursor_x}) + $signed({{6{dx[8]}}, dx});
    assign sum_y = $signed({2'b0, r_cursor_y}) - $signed({{6{dy[8]}}, dy});

    always_comb begin
        if (sum_x[14]) begin
            clamp_x = '0;
        end else if (sum_x[13:0] >= {1'b0, w_lim}) begin
            clamp_x = w_lim - BOUND_W'(1);
        end else begin
            clamp_x = sum_x[CURSOR_W-1:0];
        end
        if (sum_y[14]) begin
            clamp_y = '0;
        end else if (sum_y[13:0] >= {1'b0, h_lim}) begin
            clamp_y = h_lim - BOUND_W'(1);
        end else begin
            clamp_y = sum_y[CURSOR_W-1:0];
        end
    end

    always_comb begin
        n_cursor_x = r_cursor_x;
        n_cursor_y = r_cursor_y;
        n_buttons  = r_buttons;
        if (motion) begin
            n_cursor_x = clamp_x;
            n_cursor_y = clamp_y;
            n_buttons  = r_header[BTN_W-1:0];
        end else if (i_item.op == OP_SET_POS) begin
            n_cursor_x = {1'b0, i_item.new_x};
            n_cursor_y = {1'b0, i_item.new_y};
        end
        wheel_after = r_wheel;
        if (wheel_add) begin
            wheel_after = r_wheel + {{28{i_item.rx_byte[3]}}, i_item.rx_byte[3:0]};
        end
        n_wheel = wheel_after;
        if (i_item.op == OP_TAKE_SCROLL) begin
            n_wheel = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_cursor_x <= '0;
            r_cursor_y <= '0;
            r_buttons  <= '0;
            r_wheel    <= '0;
        end else if (i_advance) begin
            r_phase    <= n_phase;
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
            r_buttons  <= n_buttons;
            r_wheel    <= n_wheel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_header <= n_header;
            r_x_byte <= n_x_byte;
            r_y_byte <= n_y_byte;
        end
    end

    assign o_result.pos_x        = n_cursor_x[POS_W-1:0];
    assign o_result.pos_y        = n_cursor_y[POS_W-1:0];
    assign o_result.button_bits  = n_buttons;
    assign o_result.scroll_total = wheel_after;
    assign o_result.packet_done  = motion;

`ifndef SYNTH
    a_done_needs_aux: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.packet_done |-> (i_item.op == OP_RX_BYTE && i_item.from_aux))
        else $error("packet completed without an auxiliary byte");

    a_header_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_phase == PH_HEADER && n_phase == PH_XDELTA) |-> i_item.rx_byte[3])
        else $error("packet started on a byte without the sync bit");

    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.packet_done |-> (n_cursor_x < w_lim && n_cursor_y < h_lim))
        else $error("cursor outside bounds after packet");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> ($stable(r_phase) && $stable(r_wheel) && $stable(r_cursor_x)))
        else $error("state changed without a request");

    a_scroll_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_item.op == OP_TAKE_SCROLL) |=> (r_wheel == '0))
        else $error("scroll total not cleared after take");
`endif

endmodule
